// ===== sv/lru_pr_pkg.sv =====
package lru_pr_pkg;

  localparam int PAGE_W    = 7;
  localparam int NUM_PAGES = 1 << PAGE_W;
  localparam int FRAME_W   = 8;
  localparam int HIT_W     = 32;

  localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(NUM_PAGES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_APPEND,
    ST_DONE
  } state_t;

  // How an accepted reference changes the recency list.
  typedef enum logic [1:0] {
    K_HIT_STAY,   // hit on the newest page: list unchanged
    K_HIT_MOVE,   // hit elsewhere: unlink, then append
    K_FILL,       // miss with a free frame: append
    K_EVICT       // miss, no free frame: drop oldest, then append
  } kind_t;

  typedef struct packed {
    logic accept;
    logic link;
    logic append;
    logic finish;
  } cmd_t;

endpackage

// ===== sv/lru_pr_in_if.sv =====
interface lru_pr_in_if;
  logic                           valid;
  logic                           ready;
  logic [lru_pr_pkg::PAGE_W-1:0]  page_number;
  logic                           end_of_run;

  modport source (output valid, output page_number, output end_of_run, input ready);
  modport sink   (input valid, input page_number, input end_of_run, output ready);
endinterface

// ===== sv/lru_pr_out_if.sv =====
interface lru_pr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic                           evicted_valid;
  logic [lru_pr_pkg::PAGE_W-1:0]  evicted_page;
  logic [lru_pr_pkg::HIT_W-1:0]   hit_count;

  modport source (output valid, output hit, output evicted_valid, output evicted_page,
                  output hit_count, input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                  input hit_count, output ready);
endinterface

// ===== sv/lru_pr_ram.sv =====
module lru_pr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== sv/lru_pr_ctrl.sv =====
module lru_pr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lru_pr_pkg::cmd_t  cmd
);

  lru_pr_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lru_pr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      lru_pr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = lru_pr_pkg::ST_LINK;
        end
      end
      lru_pr_pkg::ST_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = lru_pr_pkg::ST_APPEND;
      end
      lru_pr_pkg::ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = lru_pr_pkg::ST_DONE;
      end
      lru_pr_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lru_pr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lru_pr_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/lru_pr_dp.sv =====
module lru_pr_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lru_pr_pkg::cmd_t                cmd,
  input  logic                            cfg_we,
  input  logic [lru_pr_pkg::FRAME_W-1:0]  cfg_wdata,
  input  logic [lru_pr_pkg::PAGE_W-1:0]   in_page_number,
  input  logic                            in_end_of_run,
  output logic                            out_hit,
  output logic                            out_evicted_valid,
  output logic [lru_pr_pkg::PAGE_W-1:0]   out_evicted_page,
  output logic [lru_pr_pkg::HIT_W-1:0]    out_hit_count
);

  localparam int PW = lru_pr_pkg::PAGE_W;
  localparam int NP = lru_pr_pkg::NUM_PAGES;
  localparam int FW = lru_pr_pkg::FRAME_W;
  localparam int HW = lru_pr_pkg::HIT_W;

  // control state
  logic [NP-1:0] resident_r, resident_nxt;
  logic [NP-1:0] newer_valid_r, newer_valid_nxt;
  logic [PW-1:0] oldest_r, oldest_nxt;
  logic [PW-1:0] newest_r, newest_nxt;
  logic [FW-1:0] frames_used_r, frames_used_nxt;
  logic [HW-1:0] hits_r, hits_nxt;
  logic [FW-1:0] frame_count_r, frame_count_nxt;

  // per-item payload
  logic [PW-1:0]     page_r;
  logic              eor_r;
  lru_pr_pkg::kind_t kind_r;
  logic              nonempty_r;
  logic              hit_r;
  logic              ev_valid_r;
  logic [PW-1:0]     ev_page_r;

  // link memories
  logic          older_we, newer_we;
  logic [PW-1:0] older_waddr, newer_waddr;
  logic [PW-1:0] older_wdata, newer_wdata;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] older_rdata, newer_rdata;

  logic [FW-1:0]     limit;
  logic              in_resident;
  lru_pr_pkg::kind_t kind_new;

  lru_pr_ram #(.WIDTH(PW), .DEPTH(NP)) u_older (
    .clk   (clk),
    .we    (older_we),
    .waddr (older_waddr),
    .wdata (older_wdata),
    .re    (cmd.accept),
    .raddr (rd_addr),
    .rdata (older_rdata)
  );

  lru_pr_ram #(.WIDTH(PW), .DEPTH(NP)) u_newer (
    .clk   (clk),
    .we    (newer_we),
    .waddr (newer_waddr),
    .wdata (newer_wdata),
    .re    (cmd.accept),
    .raddr (rd_addr),
    .rdata (newer_rdata)
  );

  // classify the incoming reference
  always_comb begin
    limit       = (frame_count_r == '0) ? FW'(1) : frame_count_r;
    in_resident = resident_r[in_page_number];
    if (in_resident) begin
      kind_new = newer_valid_r[in_page_number] ? lru_pr_pkg::K_HIT_MOVE
                                               : lru_pr_pkg::K_HIT_STAY;
    end else if (frames_used_r < limit) begin
      kind_new = lru_pr_pkg::K_FILL;
    end else begin
      kind_new = lru_pr_pkg::K_EVICT;
    end
    // hits read the page's links, evictions read the oldest page's links
    rd_addr = in_resident ? in_page_number : oldest_r;
  end

  always_comb begin
    resident_nxt    = resident_r;
    newer_valid_nxt = newer_valid_r;
    oldest_nxt      = oldest_r;
    newest_nxt      = newest_r;
    frames_used_nxt = frames_used_r;
    hits_nxt        = hits_r;
    frame_count_nxt = cfg_we ? cfg_wdata : frame_count_r;
    older_we        = 1'b0;
    older_waddr     = page_r;
    older_wdata     = newest_r;
    newer_we        = 1'b0;
    newer_waddr     = newest_r;
    newer_wdata     = page_r;

    if (cmd.link) begin
      case (kind_r)
        lru_pr_pkg::K_HIT_STAY: begin
          if (hits_r != '1) hits_nxt = hits_r + HW'(1);
        end
        lru_pr_pkg::K_HIT_MOVE: begin
          if (hits_r != '1) hits_nxt = hits_r + HW'(1);
          // unlink: the newer neighbor takes the older neighbor
          older_we    = 1'b1;
          older_waddr = newer_rdata;
          older_wdata = older_rdata;
          if (oldest_r == page_r) begin
            oldest_nxt = newer_rdata;
          end else begin
            newer_we    = 1'b1;
            newer_waddr = older_rdata;
            newer_wdata = newer_rdata;
          end
        end
        lru_pr_pkg::K_FILL: begin
          frames_used_nxt = frames_used_r + FW'(1);
        end
        lru_pr_pkg::K_EVICT: begin
          resident_nxt[oldest_r]    = 1'b0;
          newer_valid_nxt[oldest_r] = 1'b0;
          if (newer_valid_r[oldest_r]) oldest_nxt = newer_rdata;
        end
        default: ;
      endcase
    end

    if (cmd.append && kind_r != lru_pr_pkg::K_HIT_STAY) begin
      resident_nxt[page_r]    = 1'b1;
      newer_valid_nxt[page_r] = 1'b0;
      if (nonempty_r) begin
        older_we                  = 1'b1;
        newer_we                  = 1'b1;
        newer_valid_nxt[newest_r] = 1'b1;
      end else begin
        oldest_nxt = page_r;
      end
      newest_nxt = page_r;
    end

    // end of run: clear the table after the result is loaded
    if (cmd.finish && eor_r) begin
      resident_nxt    = '0;
      newer_valid_nxt = '0;
      oldest_nxt      = '0;
      newest_nxt      = '0;
      frames_used_nxt = '0;
      hits_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resident_r    <= '0;
      newer_valid_r <= '0;
      oldest_r      <= '0;
      newest_r      <= '0;
      frames_used_r <= '0;
      hits_r        <= '0;
      frame_count_r <= lru_pr_pkg::FRAME_RESET;
    end else begin
      resident_r    <= resident_nxt;
      newer_valid_r <= newer_valid_nxt;
      oldest_r      <= oldest_nxt;
      newest_r      <= newest_nxt;
      frames_used_r <= frames_used_nxt;
      hits_r        <= hits_nxt;
      frame_count_r <= frame_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r <= in_page_number;
      eor_r  <= in_end_of_run;
      kind_r <= kind_new;
    end
    if (cmd.link) begin
      hit_r      <= kind_r inside {lru_pr_pkg::K_HIT_STAY, lru_pr_pkg::K_HIT_MOVE};
      ev_valid_r <= (kind_r == lru_pr_pkg::K_EVICT);
      ev_page_r  <= (kind_r == lru_pr_pkg::K_EVICT) ? oldest_r : '0;
      case (kind_r)
        lru_pr_pkg::K_HIT_MOVE: nonempty_r <= 1'b1;
        lru_pr_pkg::K_FILL:     nonempty_r <= (frames_used_r != '0);
        lru_pr_pkg::K_EVICT:    nonempty_r <= newer_valid_r[oldest_r];
        default:                nonempty_r <= 1'b0;
      endcase
    end
    if (cmd.finish) begin
      out_hit           <= hit_r;
      out_evicted_valid <= ev_valid_r;
      out_evicted_page  <= ev_page_r;
      out_hit_count     <= hits_r;
    end
  end

endmodule

// ===== sv/lru_page_replacement_top.sv =====
// LRU page replacement tracker.
//
// Input channel in_ch carries one page reference per item (page_number and
// an end_of_run mark). Output channel out_ch returns exactly one result per
// item: hit, evicted_valid, evicted_page and the saturating hit_count of the
// current run. Both channels move an item when valid and ready are high at a
// rising clock edge.
// cfg_we/cfg_wdata write frame_count (0 acts as 1). Write it only while idle.
//
// Steps: an item passes through these from acceptance to the next acceptance:
// accept (link memories read), unlink step, append step, result load. The
// registered read and the single write port of each link RAM keep the steps
// apart. The result is valid the cycle after the load step. A new item is
// accepted while a result still waits in the output register; if the
// receiver stalls, the next item stops at its load step until it frees.
//
// Reset (rst_n low, synchronous) empties the table, zeroes the counters and
// sets frame_count to 128. The link RAMs need no clearing. An end_of_run
// item clears table and counters right after its result is loaded.
module lru_page_replacement_top (
  input  logic                           clk,
  input  logic                           rst_n,
  lru_pr_in_if.sink                      in_ch,
  lru_pr_out_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [lru_pr_pkg::FRAME_W-1:0] cfg_wdata
);

  lru_pr_pkg::cmd_t cmd;

  // sequencer: one item at a time through the four steps
  lru_pr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // recency list, residency flags, counters and result register
  lru_pr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_page_number    (in_ch.page_number),
    .in_end_of_run     (in_ch.end_of_run),
    .out_hit           (out_ch.hit),
    .out_evicted_valid (out_ch.evicted_valid),
    .out_evicted_page  (out_ch.evicted_page),
    .out_hit_count     (out_ch.hit_count)
  );

  // at most one step per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.link, cmd.append, cmd.finish}))
    else $error("more than one step commanded");

  // an accepted item always walks unlink then append
  a_accept_link: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.link ##1 cmd.append)
    else $error("step order broken after accept");

  // a loaded result is presented next cycle
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid)
    else $error("result not presented after load");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.evicted_valid))
    else $error("hit reported with eviction");

endmodule

// ===== sim/lru_page_replacement_top_tb.sv =====
module lru_page_replacement_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lru_pr_pkg::*;

  // Run length: total references, and how many at the end run with no idling.
  localparam int ITEMS        = 1650;
  localparam int CALM_ITEMS   = 150;
  // Idle cycles before a register write, after the last result is back.
  localparam int SETTLE       = 8;
  // Receiver hold-off that backs the block up into its input.
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_AT      = 300;
  localparam int NUM_DIRECTED = 24;
  localparam int NUM_SWEEP    = 9;

  typedef struct packed {
    logic              hit;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic [HIT_W-1:0]  hits;
  } res_t;

  // One directed row: an optional frame_count write ahead of the reference,
  // then the reference itself; typed rows carry the result read off by hand.
  typedef struct packed {
    logic               cfg_set;
    logic [FRAME_W-1:0] cfg_val;
    logic [PAGE_W-1:0]  page;
    logic               eor;
    logic               typed;
    res_t               want;
  } row_t;

  localparam row_t DIRECTED [NUM_DIRECTED] = '{
    // frame_count 128 from reset: fill, hit on newest, hit that moves the oldest
    '{1'b0, 8'd0,   7'd0,   1'b0, 1'b1, '{1'b0, 1'b0, 7'd0,   32'd0}},
    '{1'b0, 8'd0,   7'd0,   1'b0, 1'b1, '{1'b1, 1'b0, 7'd0,   32'd1}},
    '{1'b0, 8'd0,   7'd127, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd0,   32'd1}},
    '{1'b0, 8'd0,   7'd127, 1'b0, 1'b1, '{1'b1, 1'b0, 7'd0,   32'd2}},
    '{1'b0, 8'd0,   7'd0,   1'b0, 1'b1, '{1'b1, 1'b0, 7'd0,   32'd3}},
    // end of run: result still counts, table and hit count cleared after it
    '{1'b0, 8'd0,   7'd64,  1'b1, 1'b1, '{1'b0, 1'b0, 7'd0,   32'd3}},
    '{1'b0, 8'd0,   7'd0,   1'b0, 1'b1, '{1'b0, 1'b0, 7'd0,   32'd0}},
    // two frames: evictions of the oldest page
    '{1'b1, 8'd2,   7'd1,   1'b0, 1'b1, '{1'b0, 1'b0, 7'd0,   32'd0}},
    '{1'b0, 8'd0,   7'd2,   1'b0, 1'b1, '{1'b0, 1'b1, 7'd0,   32'd0}},
    '{1'b0, 8'd0,   7'd1,   1'b0, 1'b1, '{1'b1, 1'b0, 7'd0,   32'd1}},
    '{1'b0, 8'd0,   7'd3,   1'b0, 1'b1, '{1'b0, 1'b1, 7'd2,   32'd1}},
    // zero frames acts as one, and drops below the frames already used
    '{1'b1, 8'd0,   7'd3,   1'b0, 1'b1, '{1'b1, 1'b0, 7'd0,   32'd2}},
    '{1'b0, 8'd0,   7'd5,   1'b0, 1'b1, '{1'b0, 1'b1, 7'd1,   32'd2}},
    '{1'b0, 8'd0,   7'd6,   1'b0, 1'b1, '{1'b0, 1'b1, 7'd3,   32'd2}},
    '{1'b0, 8'd0,   7'd7,   1'b1, 1'b1, '{1'b0, 1'b1, 7'd5,   32'd2}},
    // largest register value, then one frame evicting the top page
    '{1'b1, 8'd255, 7'd127, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd0,   32'd0}},
    '{1'b1, 8'd1,   7'd126, 1'b0, 1'b1, '{1'b0, 1'b1, 7'd127, 32'd0}},
    '{1'b0, 8'd0,   7'd126, 1'b0, 1'b1, '{1'b1, 1'b0, 7'd0,   32'd1}},
    // back to the reset size with a resident page left over
    '{1'b1, 8'd128, 7'd85,  1'b0, 1'b0, '0},
    '{1'b0, 8'd0,   7'd42,  1'b0, 1'b0, '0},
    '{1'b0, 8'd0,   7'd85,  1'b0, 1'b0, '0},
    '{1'b0, 8'd0,   7'd126, 1'b0, 1'b0, '0},
    '{1'b0, 8'd0,   7'd0,   1'b0, 1'b0, '0},
    '{1'b0, 8'd0,   7'd127, 1'b1, 1'b0, '0}
  };

  // Register values the first random phases step through.
  localparam logic [FRAME_W-1:0] FRAME_SWEEP [NUM_SWEEP] = '{
    8'd1, 8'd128, 8'd0, 8'd2, 8'd255, 8'd3, 8'd127, 8'd4, 8'd64
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [FRAME_W-1:0] cfg_wdata;

  lru_pr_in_if  in_ch ();
  lru_pr_out_if out_ch ();

  lru_page_replacement_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted view of the block: residency, recency list, counters, register.
  logic               resident   [NUM_PAGES];
  logic [PAGE_W-1:0]  older_of   [NUM_PAGES];
  logic [PAGE_W-1:0]  newer_of   [NUM_PAGES];
  logic               has_newer  [NUM_PAGES];
  logic [PAGE_W-1:0]  oldest_pg;
  logic [PAGE_W-1:0]  newest_pg;
  int unsigned        frames_used;
  logic [HIT_W-1:0]   hit_total;
  logic [FRAME_W-1:0] frame_reg;

  res_t pending_res [$];   // results owed by the block, oldest first
  int   errors    = 0;
  int   sent      = 0;
  int   n_results = 0;
  bit   calm      = 1'b0;  // set for the tail of the run: no idling on either side

  function automatic void clear_table();
    for (int i = 0; i < NUM_PAGES; i++) begin
      resident[i]  = 1'b0;
      older_of[i]  = '0;
      newer_of[i]  = '0;
      has_newer[i] = 1'b0;
    end
    oldest_pg   = '0;
    newest_pg   = '0;
    frames_used = 0;
    hit_total   = '0;
  endfunction

  // Link page p in at the newest end; nonempty says the list already holds pages.
  function automatic void push_newest(input logic [PAGE_W-1:0] p, input logic nonempty);
    has_newer[p] = 1'b0;
    if (nonempty) begin
      older_of[p]         = newest_pg;
      newer_of[newest_pg] = p;
      has_newer[newest_pg] = 1'b1;
    end else begin
      older_of[p] = '0;
      oldest_pg   = p;
    end
    newest_pg = p;
  endfunction

  // Apply one reference to the predicted state and return the result it owes.
  function automatic res_t lru_predict(input logic [PAGE_W-1:0] pg, input logic eor);
    res_t              r;
    int unsigned       lim;
    logic [PAGE_W-1:0] nx;
    logic [PAGE_W-1:0] victim;
    logic              keep;
    r   = '0;
    lim = (frame_reg == '0) ? 1 : int'(frame_reg);
    if (resident[pg]) begin
      r.hit = 1'b1;
      if (hit_total != '1) hit_total++;
      // A hit on the newest page leaves the list alone.
      if (has_newer[pg]) begin
        nx = newer_of[pg];
        if (oldest_pg == pg) oldest_pg = nx;
        else newer_of[older_of[pg]] = nx;
        older_of[nx] = older_of[pg];
        push_newest(pg, 1'b1);
      end
    end else if (frames_used < lim) begin
      keep = (frames_used != 0);
      frames_used++;
      resident[pg] = 1'b1;
      push_newest(pg, keep);
    end else begin
      // No free frame: drop the oldest page, frames_used stays put.
      victim       = oldest_pg;
      keep         = has_newer[victim];
      r.ev_valid   = 1'b1;
      r.ev_page    = victim;
      resident[victim] = 1'b0;
      if (keep) oldest_pg = newer_of[victim];
      has_newer[victim] = 1'b0;
      resident[pg] = 1'b1;
      push_newest(pg, keep);
    end
    r.hits = hit_total;
    if (eor) clear_table();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Offer one reference, hold it until accepted, then log what it owes.
  task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic eor,
                          input logic typed, input res_t want);
    res_t pred;
    in_ch.valid       <= 1'b1;
    in_ch.page_number <= pg;
    in_ch.end_of_run  <= eor;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = lru_predict(pg, eor);
    pending_res.push_back(typed ? want : pred);
    sent++;
    calm = (sent >= ITEMS - CALM_ITEMS);
  endtask

  // Drop valid for a random burst, except in quiet stretches and the tail.
  task automatic maybe_gap();
    if (!calm && (sent / 100) % 3 != 1 && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Drain the block, let it settle, then write frame_count.
  task automatic write_frames(input logic [FRAME_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    frame_reg = val;
  endtask

  // Stimulus: reset, directed table, then random phases of frame_count.
  initial begin : ref_source
    logic [FRAME_W-1:0] fc;
    logic [PAGE_W-1:0]  pg;
    int unsigned        eff;
    int unsigned        win;
    int unsigned        base;
    int                 len;
    int                 ph;
    in_ch.valid       <= 1'b0;
    in_ch.page_number <= '0;
    in_ch.end_of_run  <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    clear_table();
    frame_reg = FRAME_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].cfg_set) write_frames(DIRECTED[i].cfg_val);
      send_ref(DIRECTED[i].page, DIRECTED[i].eor, DIRECTED[i].typed, DIRECTED[i].want);
      maybe_gap();
    end

    // Each phase works a window a bit wider than the frames, so hits and
    // evictions both come often; a few references land anywhere.
    ph = 0;
    while (sent < ITEMS) begin
      if (ph < NUM_SWEEP) fc = FRAME_SWEEP[ph];
      else if ($urandom_range(0, 3) == 0) fc = FRAME_W'($urandom_range(0, 255));
      else fc = FRAME_W'($urandom_range(1, 20));
      write_frames(fc);
      eff = (fc == '0) ? 1 : int'(fc);
      win = eff + $urandom_range(0, eff / 2 + 2);
      if (win > NUM_PAGES) win = NUM_PAGES;
      base = $urandom_range(0, NUM_PAGES - 1);
      len  = $urandom_range(40, 120);
      for (int k = 0; k < len && sent < ITEMS; k++) begin
        if ($urandom_range(0, 31) == 0) base = $urandom_range(0, NUM_PAGES - 1);
        if ($urandom_range(0, 4) != 0) pg = PAGE_W'((base + $urandom_range(0, win - 1)) % NUM_PAGES);
        else pg = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
        send_ref(pg, $urandom_range(0, 79) == 0, 1'b0, '0);
        maybe_gap();
      end
      ph++;
    end

    // Wait out every owed result, then a few more cycles for strays.
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: random ready bursts, one long hold-off, quiet stretches.
  initial begin : result_sink
    bit held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && n_results >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && (n_results / 100) % 3 != 2 && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest owed one.
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_results++;
      if (pending_res.size() == 0) begin
        report_mismatch("result with no reference outstanding");
      end else begin
        exp_r = pending_res.pop_front();
        if (out_ch.hit !== exp_r.hit)
          report_mismatch($sformatf("result %0d hit %b, want %b",
                                    n_results, out_ch.hit, exp_r.hit));
        if (out_ch.evicted_valid !== exp_r.ev_valid)
          report_mismatch($sformatf("result %0d evicted_valid %b, want %b",
                                    n_results, out_ch.evicted_valid, exp_r.ev_valid));
        if (out_ch.evicted_page !== exp_r.ev_page)
          report_mismatch($sformatf("result %0d evicted_page %0d, want %0d",
                                    n_results, out_ch.evicted_page, exp_r.ev_page));
        if (out_ch.hit_count !== exp_r.hits)
          report_mismatch($sformatf("result %0d hit_count %0d, want %0d",
                                    n_results, out_ch.hit_count, exp_r.hits));
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
